// ===== hdl/arld_pkg.sv =====
// Package for the alternating run-length decoder.
// Holds command and status codes and the structs passed between the front,
// the queue and the back. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arld_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // Track status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MID_RUN   = 2'd1,
    ST_EARLY_END = 2'd2
  } status_e;

  // Bytes per result word
  localparam int unsigned OutLanes = 4;
  // Entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // One decoded operation: cnt copies of byte starting at woff
  typedef struct packed {
    logic [7:0]  byte_val;
    logic [7:0]  cnt;
    logic [14:0] woff;
    logic        done;
    status_e     status;
  } op_t;

  // One result word
  typedef struct packed {
    logic [OutLanes-1:0][7:0] lanes;
    logic [2:0]               byte_count;
    logic [13:0]              write_offset;
    logic                     track_done;
    status_e                  status;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/arld_front.sv =====
// Front end of the alternating run-length decoder: parses compressed words.
// Tracks run phase, remaining count, offset and run length; emits one op_t
// per accepted word. Depends on arld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arld_front #(
  parameter int unsigned TRACK_MAX = 16384
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [15:0]      compressed_length_i,
  input  wire logic [14:0]      track_length_i,
  output arld_pkg::op_t         op_o
);

  localparam int unsigned LimCap = (TRACK_MAX < 32767) ? TRACK_MAX : 32767;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LIT_LEN,
    PH_LIT_DATA,
    PH_REP_COUNT,
    PH_REP_BYTE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] rem_q, rem_d;
  logic [14:0] off_q, off_d;
  logic [7:0]  run_q, run_d;

  logic [14:0] limit;
  logic [14:0] room;
  logic [15:0] rem_dec;
  logic [7:0]  run_dec;
  logic [7:0]  lit_run;
  logic [7:0]  rep_n;
  logic        end_trk;
  arld_pkg::status_e end_st;

  // Derive limit, room and decremented counts
  assign limit   = (track_length_i < 15'(LimCap)) ? track_length_i : 15'(LimCap);
  assign room    = (off_q < limit) ? (limit - off_q) : 15'd0;
  assign rem_dec = (rem_q != 16'd0) ? (rem_q - 16'd1) : 16'd0;
  assign run_dec = (run_q != 8'd0) ? (run_q - 8'd1) : 8'd0;
  assign lit_run = ({8'd0, data_byte_i} > rem_dec) ? rem_dec[7:0] : data_byte_i;
  assign rep_n   = ({7'd0, run_q} < room) ? run_q : room[7:0];

  // Classify the word and advance the parse state
  always_comb begin
    phase_d        = phase_q;
    rem_d          = rem_q;
    off_d          = off_q;
    run_d          = run_q;
    end_trk        = 1'b0;
    end_st         = arld_pkg::ST_OK;
    op_o.byte_val  = data_byte_i;
    op_o.cnt       = 8'd0;
    op_o.woff      = off_q;
    op_o.done      = 1'b0;
    op_o.status    = arld_pkg::ST_OK;

    unique case (arld_pkg::cmd_e'(cmd_i))
      arld_pkg::CMD_START: begin
        rem_d     = compressed_length_i;
        off_d     = 15'd0;
        op_o.woff = 15'd0;
        run_d     = 8'd0;
        if (compressed_length_i == 16'd0) begin
          end_trk = 1'b1;
        end else begin
          phase_d = PH_LIT_LEN;
        end
      end
      arld_pkg::CMD_DATA: begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_LIT_LEN: begin
            rem_d = rem_dec;
            if (rem_dec == 16'd0) begin
              end_trk = 1'b1;
              end_st  = arld_pkg::ST_MID_RUN;
            end else begin
              run_d   = lit_run;
              phase_d = (lit_run != 8'd0) ? PH_LIT_DATA : PH_REP_COUNT;
            end
          end
          PH_LIT_DATA: begin
            rem_d = rem_dec;
            run_d = run_dec;
            if (room != 15'd0) begin
              op_o.cnt = 8'd1;
              off_d    = off_q + 15'd1;
            end
            if (run_dec == 8'd0) begin
              if (rem_dec == 16'd0) begin
                end_trk = 1'b1;
              end else begin
                phase_d = PH_REP_COUNT;
              end
            end
          end
          PH_REP_COUNT: begin
            rem_d = rem_dec;
            if (rem_dec == 16'd0) begin
              end_trk = 1'b1;
              end_st  = arld_pkg::ST_MID_RUN;
            end else begin
              run_d   = data_byte_i;
              phase_d = PH_REP_BYTE;
            end
          end
          PH_REP_BYTE: begin
            rem_d    = rem_dec;
            op_o.cnt = rep_n;
            off_d    = off_q + 15'(rep_n);
            run_d    = 8'd0;
            if (rem_dec == 16'd0) begin
              end_trk = 1'b1;
            end else begin
              phase_d = PH_LIT_LEN;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      arld_pkg::CMD_END: begin
        if (phase_q != PH_IDLE) begin
          end_trk = 1'b1;
          end_st  = arld_pkg::ST_EARLY_END;
        end
      end
      arld_pkg::CMD_RSVD: begin
      end
    endcase

    // Close the track
    if (end_trk) begin
      op_o.done   = 1'b1;
      op_o.status = end_st;
      phase_d     = PH_IDLE;
      rem_d       = 16'd0;
      run_d       = 8'd0;
    end
  end

  // Hold parse state; advance on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q   <= 16'd0;
      off_q   <= 15'd0;
      run_q   <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      run_q   <= run_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arld_queue.sv =====
// Short operation queue between front and back of the run-length decoder.
// Register-based FIFO of arld_pkg::op_t, depth arld_pkg::QueueDepth.
// Depends on arld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arld_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  arld_pkg::op_t op_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output arld_pkg::op_t op_o,
  output logic          valid_o
);

  localparam int unsigned Depth = arld_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  arld_pkg::op_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/arld_back.sv =====
// Back end of the run-length decoder: splits each op into result words.
// Emits up to four bytes per word into a one-word output register.
// Depends on arld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arld_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  arld_pkg::op_t  op_i,
  input  wire logic      op_valid_i,
  output logic           op_pop_o,
  output arld_pkg::res_t res_o,
  output logic           res_valid_o,
  input  wire logic      res_pop_i
);

  localparam int unsigned Lanes = arld_pkg::OutLanes;

  logic [7:0]     pos_q;
  logic [7:0]     left;
  logic           more;
  logic           load;
  logic [2:0]     emit_cnt;
  logic [14:0]    woff_sum;
  arld_pkg::res_t res_d, res_q;
  logic           valid_q;

  assign left     = op_i.cnt - pos_q;
  assign more     = (left > 8'(Lanes));
  assign emit_cnt = more ? 3'(Lanes) : left[2:0];
  assign woff_sum = op_i.woff + 15'(pos_q);
  assign load     = op_valid_i && (!valid_q || res_pop_i);
  assign op_pop_o = load && !more;

  // Build the next result word
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      res_d.lanes[i] = (3'(i) < emit_cnt) ? op_i.byte_val : 8'd0;
    end
    res_d.byte_count   = emit_cnt;
    res_d.write_offset = woff_sum[13:0];
    res_d.track_done   = more ? 1'b0 : op_i.done;
    res_d.status       = more ? arld_pkg::ST_OK : op_i.status;
    res_d.last         = !more;
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  // Advance position within the op and track output occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 8'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= more ? (pos_q + 8'(Lanes)) : 8'd0;
      end else if (res_pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = valid_q;

`ifndef ASSERT_OFF
  // A word that is not the last of its op is always full and carries no end
  a_mid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.last) |-> (res_q.byte_count == 3'(Lanes) && !res_q.track_done))
    else $error("partial or ending word before last");

  // Error status only appears with track done
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.status != arld_pkg::ST_OK) |-> res_q.track_done)
    else $error("error status without track done");

  // Position within an op stays zero between ops
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |=> (pos_q == 8'd0))
    else $error("position not cleared after op");

  // A stalled output word holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_pop_i) |=> (valid_q && $stable(res_q)))
    else $error("output word changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/alternating_run_length_decoder.sv =====
// Top level of the alternating run-length decoder.
// Instantiates arld_front, arld_queue and arld_back; uses arld_pkg.
//
//   channel  | handshake      | payload
//   ---------+----------------+---------------------------------------------
//   input    | push / full    | cmd_i, data_byte_i, compressed_length_i
//   result   | empty / pop    | lane0_o..lane3_o, byte_count_o, write_offset_o,
//            |                | track_done_o, status_o, last_o
//   config   | cfg_we_i       | cfg_wdata_i (track_length)
//
// The front parses one word per cycle while the two-entry op queue has room.
// The back emits one result word per cycle while its output is free or popped:
// an op of n repeat bytes gives max(1, ceil(n/4)) words, every other op one.
// Reset is asynchronous, active low; no clearing pass, ready the cycle after.
// full rises when the op queue is full; a stalled result holds on the ports.
`timescale 1ns / 1ps
`default_nettype none

module alternating_run_length_decoder #(
  parameter int unsigned TRACK_MAX = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] compressed_length_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       lane0_o,
  output logic [7:0]       lane1_o,
  output logic [7:0]       lane2_o,
  output logic [7:0]       lane3_o,
  output logic [2:0]       byte_count_o,
  output logic [13:0]      write_offset_o,
  output logic             track_done_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [14:0] cfg_wdata_i
);

  localparam logic [14:0] TrackLenReset = 15'd9216;

  logic [14:0]    track_len_q;
  logic           accept;
  arld_pkg::op_t  front_op, queue_op;
  logic           queue_valid, queue_pop, res_valid;
  arld_pkg::res_t res;

  assign accept = push && !full;

  // Hold the track length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_len_q <= TrackLenReset;
    end else if (cfg_we_i) begin
      track_len_q <= cfg_wdata_i;
    end
  end

  arld_front #(
    .TRACK_MAX (TRACK_MAX)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .cmd_i               (cmd_i),
    .data_byte_i         (data_byte_i),
    .compressed_length_i (compressed_length_i),
    .track_length_i      (track_len_q),
    .op_o                (front_op)
  );

  arld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .op_i    (front_op),
    .full_o  (full),
    .pop_i   (queue_pop),
    .op_o    (queue_op),
    .valid_o (queue_valid)
  );

  arld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (queue_op),
    .op_valid_i  (queue_valid),
    .op_pop_o    (queue_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  // Unpack the result word onto the ports
  assign empty          = !res_valid;
  assign lane0_o        = res.lanes[0];
  assign lane1_o        = res.lanes[1];
  assign lane2_o        = res.lanes[2];
  assign lane3_o        = res.lanes[3];
  assign byte_count_o   = res.byte_count;
  assign write_offset_o = res.write_offset;
  assign track_done_o   = res.track_done;
  assign status_o       = res.status;
  assign last_o         = res.last;

endmodule

`default_nettype wire
